>>> sv/bbpt_pkg.sv
package bbpt_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int MAX_TESS    = 256;
  localparam int TESS_W      = 9;
  localparam int QUEUE_DEPTH = 2;
  localparam int ACC_W       = 48;
  localparam int PAR_W       = FRAC_BITS + 1;
  localparam int DIVD_W      = 46;
  localparam int DIVS_W      = 32;
  localparam int QUOT_W      = 17;
  localparam int NORM_ONE    = 16384;
  localparam int DEGEN_EPS   = 4295;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_CELL = 1'b1;

  typedef struct packed {
    logic               is_cell;
    logic [3:0]         slot;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [7:0]         cu;
    logic [7:0]         cv;
  } req_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

endpackage

>>> sv/bbpt_front.sv
module bbpt_front import bbpt_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_command,
  input  logic [3:0]         in_point_index,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  input  logic signed [31:0] in_coord_z,
  input  logic [7:0]         in_cell_u,
  input  logic [7:0]         in_cell_v,
  input  logic [TESS_W-1:0]  tess_eff,
  output logic               q_valid,
  output req_t               q_req,
  input  logic               q_pop
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  req_t           buf_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  cnt_r;
  logic           accept, in_range, push;
  req_t           req_in;

  assign in_ready = (cnt_r != CW'(DEPTH));
  assign accept   = in_valid && in_ready;
  assign in_range = ({1'b0, in_cell_u} < tess_eff) && ({1'b0, in_cell_v} < tess_eff);
  // out-of-range cells are taken and dropped here
  assign push     = accept && ((in_command == CMD_LOAD) || in_range);
  assign q_valid  = (cnt_r != '0);
  assign q_req    = buf_r[rd_ptr_r];

  always_comb begin
    req_in.is_cell = (in_command == CMD_CELL);
    req_in.slot    = in_point_index;
    req_in.x       = in_coord_x;
    req_in.y       = in_coord_y;
    req_in.z       = in_coord_z;
    req_in.cu      = in_cell_u;
    req_in.cv      = in_cell_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + CW'(push) - CW'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= req_in;
    end
  end

endmodule

>>> sv/bbpt_div.sv
module bbpt_div import bbpt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy_r, done_r;
  logic [4:0]        cnt_r;
  logic [DIVS_W-1:0] rem_r, dvs_r;
  logic [QUOT_W-1:0] dq_r;
  logic [DIVS_W:0]   trial, diff;
  logic              ge;

  assign trial = {rem_r, dq_r[QUOT_W-1]};
  assign ge    = (trial >= {1'b0, dvs_r});
  assign diff  = trial - {1'b0, dvs_r};

  assign rsp.done = done_r;
  assign rsp.quot = dq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == 5'(QUOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // restoring division, one quotient bit per cycle; high dividend part is below divisor
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= DIVS_W'(req.dividend[DIVD_W-1:QUOT_W]);
      dq_r  <= req.dividend[QUOT_W-1:0];
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
      dq_r  <= {dq_r[QUOT_W-2:0], ge};
    end
  end

endmodule

>>> sv/bbpt_back.sv
module bbpt_back import bbpt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  req_t               q_req,
  output logic               q_pop,
  input  logic [TESS_W-1:0]  tess_eff,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [15:0] out_norm_x,
  output logic signed [15:0] out_norm_y,
  output logic signed [15:0] out_norm_z,
  output logic [16:0]        out_tex_s,
  output logic [16:0]        out_tex_t,
  output logic               out_last
);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_DIV   = 5'd1;
  localparam logic [4:0] ST_DIVW  = 5'd2;
  localparam logic [4:0] ST_RD    = 5'd3;
  localparam logic [4:0] ST_HINIT = 5'd4;
  localparam logic [4:0] ST_HORN  = 5'd5;
  localparam logic [4:0] ST_SHA   = 5'd6;
  localparam logic [4:0] ST_SHB   = 5'd7;
  localparam logic [4:0] ST_CR    = 5'd8;
  localparam logic [4:0] ST_DG    = 5'd9;
  localparam logic [4:0] ST_DG2   = 5'd10;
  localparam logic [4:0] ST_NB    = 5'd11;
  localparam logic [4:0] ST_SQ    = 5'd12;
  localparam logic [4:0] ST_SQRT  = 5'd13;
  localparam logic [4:0] ST_NDIV  = 5'd14;
  localparam logic [4:0] ST_NDIVW = 5'd15;
  localparam logic [4:0] ST_OUT   = 5'd16;

  localparam logic [2:0] PH_RV  = 3'd0;
  localparam logic [2:0] PH_RD  = 3'd1;
  localparam logic [2:0] PH_VP  = 3'd2;
  localparam logic [2:0] PH_VDV = 3'd3;
  localparam logic [2:0] PH_VDU = 3'd4;

  localparam logic signed [ACC_W-1:0] LIM30 = ACC_W'(1073741823);
  localparam logic signed [ACC_W-1:0] PMAX  = ACC_W'(2147483647);
  localparam logic signed [ACC_W-1:0] PMIN  = -PMAX - ACC_W'(1);
  localparam logic [51:0] DEGEN_SQ = 52'(DEGEN_EPS * DEGEN_EPS);

  logic [4:0] state_r, state_nxt;
  logic [2:0] phase_r, phase_nxt;
  logic [1:0] didx_r, didx_nxt, corner_r, corner_nxt, ax_r, ax_nxt, row_r, row_nxt;
  logic [1:0] hs_r, hs_nxt, ni_r, ni_nxt;
  logic [2:0] rc_r, rc_nxt, cc_r, cc_nxt, vk_r, vk_nxt;
  logic [5:0] sh_r, sh_nxt;
  logic [7:0] cu_r, cu_nxt, cv_r, cv_nxt;
  logic [PAR_W-1:0] par_r [4], par_nxt [4];
  logic signed [ACC_W-1:0] pts_r [4], pts_nxt [4];
  logic signed [ACC_W-1:0] rowv_r [4], rowv_nxt [4];
  logic signed [ACC_W-1:0] drow_r [4], drow_nxt [4];
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [ACC_W-1:0] du_r [3], du_nxt [3], dv_r [3], dv_nxt [3];
  logic signed [62:0] crs_r [3], crs_nxt [3];
  logic [61:0] mag_r [3], mag_nxt [3], mag_c [3];
  logic [27:0] sq_r, sq_nxt;
  logic [61:0] sum_r, sum_nxt, x_r, x_nxt;
  logic [62:0] root_r, root_nxt, bit_r, bit_nxt;
  logic [31:0] len_r, len_nxt;
  logic signed [31:0] pos_r [4][3], pos_nxt [4][3];
  logic signed [15:0] nrm_r [4][3], nrm_nxt [4][3];

  logic               ov_r, ov_nxt;
  logic signed [31:0] opx_r, opy_r, opz_r, opx_nxt, opy_nxt, opz_nxt;
  logic signed [15:0] onx_r, ony_r, onz_r, onx_nxt, ony_nxt, onz_nxt;
  logic [16:0]        ots_r, ott_r, ots_nxt, ott_nxt;
  logic               olast_r, olast_nxt;

  logic [95:0] mem_r [16];
  logic [95:0] rdata_r;
  logic [3:0]  rd_addr;
  logic        mem_we;

  div_req_t dreq;
  div_rsp_t drsp;

  logic signed [ACC_W-1:0] p0, p1, p2, p3, k0, k1, k2, k3, addend, mr, hval;
  logic [PAR_W-1:0]        w;
  logic signed [65:0]      hprod, hrnd;
  logic                    hder, hlast;
  logic signed [31:0]      ma, mb;
  logic signed [63:0]      nprod;
  logic                    crs_tiny;
  logic [27:0]             sq_c;
  logic [51:0]             sq_sh;
  logic signed [31:0]      rsel;
  logic [63:0]             rb;
  logic [1:0]              cn;
  logic [8:0]              kdiv;
  logic [15:0]             q16;

  bbpt_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (dreq),
    .rsp  (drsp)
  );

  // coefficient source
  always_comb begin
    case (phase_r)
      PH_RV, PH_RD: begin
        p0 = pts_r[0]; p1 = pts_r[1]; p2 = pts_r[2]; p3 = pts_r[3];
      end
      PH_VP, PH_VDV: begin
        p0 = rowv_r[0]; p1 = rowv_r[1]; p2 = rowv_r[2]; p3 = rowv_r[3];
      end
      default: begin
        p0 = drow_r[0]; p1 = drow_r[1]; p2 = drow_r[2]; p3 = drow_r[3];
      end
    endcase
  end

  assign k0 = p3 - p0 + 48'sd3 * (p1 - p2);
  assign k1 = 48'sd3 * (p0 - (p1 <<< 1) + p2);
  assign k2 = 48'sd3 * (p1 - p0);
  assign k3 = p0;

  assign hder  = (phase_r == PH_RD) || (phase_r == PH_VDV);
  assign hlast = hder ? (hs_r == 2'd1) : (hs_r == 2'd2);
  assign w     = ((phase_r == PH_RV) || (phase_r == PH_RD)) ?
                 par_r[{1'b0, corner_r[0]}] : par_r[{1'b1, corner_r[1]}];
  assign hprod = acc_r * $signed({1'b0, w});
  assign hrnd  = (hprod + 66'sd32768) >>> FRAC_BITS;
  assign mr    = hrnd[ACC_W-1:0];

  always_comb begin
    case (hs_r)
      2'd0:    addend = hder ? (k1 <<< 1) : k1;
      2'd1:    addend = k2;
      default: addend = k3;
    endcase
  end

  assign hval = mr + addend;

  // shared multiplier for cross product and sum of squares
  always_comb begin
    if (state_r == ST_SQ) begin
      ma = $signed({2'b0, mag_r[cc_r[1:0]][29:0]});
      mb = ma;
    end else begin
      case (cc_r)
        3'd0:    begin ma = du_r[1][31:0]; mb = dv_r[2][31:0]; end
        3'd1:    begin ma = du_r[2][31:0]; mb = dv_r[1][31:0]; end
        3'd2:    begin ma = du_r[2][31:0]; mb = dv_r[0][31:0]; end
        3'd3:    begin ma = du_r[0][31:0]; mb = dv_r[2][31:0]; end
        3'd4:    begin ma = du_r[0][31:0]; mb = dv_r[1][31:0]; end
        default: begin ma = du_r[1][31:0]; mb = dv_r[0][31:0]; end
      endcase
    end
  end

  assign nprod = ma * mb;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = crs_r[i][62] ? 62'(-crs_r[i]) : crs_r[i][61:0];
    end
  end

  assign crs_tiny = (mag_c[0] < 62'(DEGEN_EPS)) && (mag_c[1] < 62'(DEGEN_EPS)) &&
                    (mag_c[2] < 62'(DEGEN_EPS));
  assign sq_c  = {15'b0, mag_c[0][12:0]} * {15'b0, mag_c[0][12:0]} +
                 {15'b0, mag_c[1][12:0]} * {15'b0, mag_c[1][12:0]} +
                 {15'b0, mag_c[2][12:0]} * {15'b0, mag_c[2][12:0]};
  assign sq_sh = {24'b0, sq_r} << {sh_r, 1'b0};
  assign rb    = {1'b0, root_r} + {1'b0, bit_r};

  always_comb begin
    case (ax_r)
      2'd0:    rsel = rdata_r[31:0];
      2'd1:    rsel = rdata_r[63:32];
      default: rsel = rdata_r[95:64];
    endcase
  end

  always_comb begin
    case (vk_r)
      3'd0:    cn = 2'd0;
      3'd1:    cn = 2'd1;
      3'd2:    cn = 2'd3;
      3'd3:    cn = 2'd0;
      3'd4:    cn = 2'd3;
      default: cn = 2'd2;
    endcase
  end

  assign kdiv     = (didx_r[1] ? {1'b0, cv_r} : {1'b0, cu_r}) + 9'(didx_r[0]);
  assign q16      = drsp.quot[15:0];
  assign rd_addr  = {row_r, rc_r[1:0]};
  assign mem_we   = (state_r == ST_IDLE) && q_valid && !q_req.is_cell;
  assign q_pop    = (state_r == ST_IDLE) && q_valid;

  always_comb begin
    dreq.start    = (state_r == ST_DIV) || (state_r == ST_NDIV);
    dreq.dividend = (state_r == ST_NDIV) ?
                    DIVD_W'({mag_r[ni_r][29:0], 14'b0}) + DIVD_W'(len_r[31:1]) :
                    DIVD_W'({kdiv, 16'b0});
    dreq.divisor  = (state_r == ST_NDIV) ? len_r : DIVS_W'(tess_eff);
  end

  always_comb begin
    state_nxt  = state_r;   phase_nxt = phase_r;  didx_nxt = didx_r;
    corner_nxt = corner_r;  ax_nxt    = ax_r;     row_nxt  = row_r;
    hs_nxt     = hs_r;      ni_nxt    = ni_r;     rc_nxt   = rc_r;
    cc_nxt     = cc_r;      vk_nxt    = vk_r;     sh_nxt   = sh_r;
    cu_nxt     = cu_r;      cv_nxt    = cv_r;     par_nxt  = par_r;
    pts_nxt    = pts_r;     rowv_nxt  = rowv_r;   drow_nxt = drow_r;
    acc_nxt    = acc_r;     du_nxt    = du_r;     dv_nxt   = dv_r;
    crs_nxt    = crs_r;     mag_nxt   = mag_r;    sq_nxt   = sq_r;
    sum_nxt    = sum_r;     x_nxt     = x_r;      root_nxt = root_r;
    bit_nxt    = bit_r;     len_nxt   = len_r;    pos_nxt  = pos_r;
    nrm_nxt    = nrm_r;
    ov_nxt     = ov_r && !out_ready;
    opx_nxt = opx_r; opy_nxt = opy_r; opz_nxt = opz_r;
    onx_nxt = onx_r; ony_nxt = ony_r; onz_nxt = onz_r;
    ots_nxt = ots_r; ott_nxt = ott_r; olast_nxt = olast_r;

    case (state_r)
      ST_IDLE: begin
        if (q_valid && q_req.is_cell) begin
          cu_nxt    = q_req.cu;
          cv_nxt    = q_req.cv;
          didx_nxt  = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        state_nxt = ST_DIVW;
      end
      ST_DIVW: begin
        if (drsp.done) begin
          par_nxt[didx_r] = drsp.quot;
          if (didx_r == 2'd3) begin
            corner_nxt = '0; ax_nxt = '0; row_nxt = '0; rc_nxt = '0;
            phase_nxt  = PH_RV;
            state_nxt  = ST_RD;
          end else begin
            didx_nxt  = didx_r + 1'b1;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_RD: begin
        if (rc_r != 3'd0) begin
          pts_nxt[2'(rc_r - 3'd1)] = ACC_W'(rsel);
        end
        rc_nxt = rc_r + 1'b1;
        if (rc_r == 3'd4) begin
          phase_nxt = PH_RV;
          state_nxt = ST_HINIT;
        end
      end
      ST_HINIT: begin
        acc_nxt   = hder ? 48'sd3 * k0 : k0;
        hs_nxt    = '0;
        state_nxt = ST_HORN;
      end
      ST_HORN: begin
        acc_nxt = hval;
        hs_nxt  = hs_r + 1'b1;
        if (hlast) begin
          state_nxt = ST_HINIT;
          case (phase_r)
            PH_RV: begin
              rowv_nxt[row_r] = hval;
              phase_nxt       = PH_RD;
            end
            PH_RD: begin
              drow_nxt[row_r] = hval;
              if (row_r == 2'd3) begin
                phase_nxt = PH_VP;
              end else begin
                row_nxt   = row_r + 1'b1;
                rc_nxt    = '0;
                phase_nxt = PH_RV;
                state_nxt = ST_RD;
              end
            end
            PH_VP: begin
              if (hval > PMAX) begin
                pos_nxt[corner_r][ax_r] = PMAX[31:0];
              end else if (hval < PMIN) begin
                pos_nxt[corner_r][ax_r] = PMIN[31:0];
              end else begin
                pos_nxt[corner_r][ax_r] = hval[31:0];
              end
              phase_nxt = PH_VDV;
            end
            PH_VDV: begin
              dv_nxt[ax_r] = hval;
              phase_nxt    = PH_VDU;
            end
            default: begin
              du_nxt[ax_r] = hval;
              if (ax_r == 2'd2) begin
                sh_nxt    = '0;
                state_nxt = ST_SHA;
              end else begin
                ax_nxt    = ax_r + 1'b1;
                row_nxt   = '0;
                rc_nxt    = '0;
                phase_nxt = PH_RV;
                state_nxt = ST_RD;
              end
            end
          endcase
        end
      end
      ST_SHA: begin
        if (du_r[0] > LIM30 || du_r[0] < -LIM30 || du_r[1] > LIM30 || du_r[1] < -LIM30 ||
            du_r[2] > LIM30 || du_r[2] < -LIM30) begin
          for (int i = 0; i < 3; i++) du_nxt[i] = du_r[i] >>> 1;
          sh_nxt = sh_r + 1'b1;
        end else begin
          state_nxt = ST_SHB;
        end
      end
      ST_SHB: begin
        if (dv_r[0] > LIM30 || dv_r[0] < -LIM30 || dv_r[1] > LIM30 || dv_r[1] < -LIM30 ||
            dv_r[2] > LIM30 || dv_r[2] < -LIM30) begin
          for (int i = 0; i < 3; i++) dv_nxt[i] = dv_r[i] >>> 1;
          sh_nxt = sh_r + 1'b1;
        end else begin
          for (int i = 0; i < 3; i++) crs_nxt[i] = '0;
          cc_nxt    = '0;
          state_nxt = ST_CR;
        end
      end
      ST_CR: begin
        if (cc_r[0]) begin
          crs_nxt[cc_r[2:1]] = crs_r[cc_r[2:1]] - nprod[62:0];
        end else begin
          crs_nxt[cc_r[2:1]] = crs_r[cc_r[2:1]] + nprod[62:0];
        end
        cc_nxt = cc_r + 1'b1;
        if (cc_r == 3'd5) begin
          state_nxt = ST_DG;
        end
      end
      ST_DG: begin
        mag_nxt   = mag_c;
        sq_nxt    = sq_c;
        state_nxt = crs_tiny ? ST_DG2 : ST_NB;
      end
      ST_DG2: begin
        if (sq_r == '0 || (sh_r < 6'd13 && sq_sh < DEGEN_SQ)) begin
          nrm_nxt[corner_r][0] = '0;
          nrm_nxt[corner_r][1] = 16'(NORM_ONE);
          nrm_nxt[corner_r][2] = '0;
          if (corner_r == 2'd3) begin
            vk_nxt    = '0;
            state_nxt = ST_OUT;
          end else begin
            corner_nxt = corner_r + 1'b1;
            ax_nxt = '0; row_nxt = '0; rc_nxt = '0;
            phase_nxt  = PH_RV;
            state_nxt  = ST_RD;
          end
        end else begin
          state_nxt = ST_NB;
        end
      end
      ST_NB: begin
        if (|{mag_r[0][61:30], mag_r[1][61:30], mag_r[2][61:30]}) begin
          for (int i = 0; i < 3; i++) mag_nxt[i] = mag_r[i] >> 1;
        end else if (!(|{mag_r[0][61:29], mag_r[1][61:29], mag_r[2][61:29]})) begin
          for (int i = 0; i < 3; i++) mag_nxt[i] = mag_r[i] << 1;
        end else begin
          cc_nxt    = '0;
          sum_nxt   = '0;
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        sum_nxt = sum_r + nprod[61:0];
        cc_nxt  = cc_r + 1'b1;
        if (cc_r == 3'd2) begin
          x_nxt     = sum_r + nprod[61:0];
          root_nxt  = '0;
          bit_nxt   = 63'd1 << 62;
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (bit_r != '0) begin
          if ({2'b0, x_r} >= rb) begin
            x_nxt    = 62'({2'b0, x_r} - rb);
            root_nxt = (root_r >> 1) + bit_r;
          end else begin
            root_nxt = root_r >> 1;
          end
          bit_nxt = bit_r >> 2;
        end else begin
          len_nxt   = root_r[31:0];
          ni_nxt    = '0;
          state_nxt = ST_NDIV;
        end
      end
      ST_NDIV: begin
        state_nxt = ST_NDIVW;
      end
      ST_NDIVW: begin
        if (drsp.done) begin
          nrm_nxt[corner_r][ni_r] = crs_r[ni_r][62] ? -$signed(q16) : $signed(q16);
          if (ni_r == 2'd2) begin
            if (corner_r == 2'd3) begin
              vk_nxt    = '0;
              state_nxt = ST_OUT;
            end else begin
              corner_nxt = corner_r + 1'b1;
              ax_nxt = '0; row_nxt = '0; rc_nxt = '0;
              phase_nxt  = PH_RV;
              state_nxt  = ST_RD;
            end
          end else begin
            ni_nxt    = ni_r + 1'b1;
            state_nxt = ST_NDIV;
          end
        end
      end
      ST_OUT: begin
        if (!ov_r || out_ready) begin
          ov_nxt    = 1'b1;
          opx_nxt   = pos_r[cn][0];
          opy_nxt   = pos_r[cn][1];
          opz_nxt   = pos_r[cn][2];
          onx_nxt   = nrm_r[cn][0];
          ony_nxt   = nrm_r[cn][1];
          onz_nxt   = nrm_r[cn][2];
          ots_nxt   = par_r[{1'b0, cn[0]}];
          ott_nxt   = par_r[{1'b1, cn[1]}];
          olast_nxt = (vk_r == 3'd5);
          vk_nxt    = vk_r + 1'b1;
          if (vk_r == 3'd5) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    phase_r <= phase_nxt;  didx_r <= didx_nxt;  corner_r <= corner_nxt;
    ax_r    <= ax_nxt;     row_r  <= row_nxt;   hs_r     <= hs_nxt;
    ni_r    <= ni_nxt;     rc_r   <= rc_nxt;    cc_r     <= cc_nxt;
    vk_r    <= vk_nxt;     sh_r   <= sh_nxt;    cu_r     <= cu_nxt;
    cv_r    <= cv_nxt;     par_r  <= par_nxt;   pts_r    <= pts_nxt;
    rowv_r  <= rowv_nxt;   drow_r <= drow_nxt;  acc_r    <= acc_nxt;
    du_r    <= du_nxt;     dv_r   <= dv_nxt;    crs_r    <= crs_nxt;
    mag_r   <= mag_nxt;    sq_r   <= sq_nxt;    sum_r    <= sum_nxt;
    x_r     <= x_nxt;      root_r <= root_nxt;  bit_r    <= bit_nxt;
    len_r   <= len_nxt;    pos_r  <= pos_nxt;   nrm_r    <= nrm_nxt;
    opx_r   <= opx_nxt;    opy_r  <= opy_nxt;   opz_r    <= opz_nxt;
    onx_r   <= onx_nxt;    ony_r  <= ony_nxt;   onz_r    <= onz_nxt;
    ots_r   <= ots_nxt;    ott_r  <= ott_nxt;   olast_r  <= olast_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[q_req.slot] <= {q_req.z, q_req.y, q_req.x};
    end
    rdata_r <= mem_r[rd_addr];
  end

  assign out_valid  = ov_r;
  assign out_pos_x  = opx_r;
  assign out_pos_y  = opy_r;
  assign out_pos_z  = opz_r;
  assign out_norm_x = onx_r;
  assign out_norm_y = ony_r;
  assign out_norm_z = onz_r;
  assign out_tex_s  = ots_r;
  assign out_tex_t  = ott_r;
  assign out_last   = olast_r;

endmodule

>>> sv/bicubic_bezier_patch_tessellator_unit.sv
// Channel | Direction | Handshake                  | Payload
// in_     | input     | in_valid / in_ready        | command, point_index, coord_x/y/z, cell_u/v
// out_    | output    | out_valid / out_ready      | pos_x/y/z, norm_x/y/z, tex_s/t, last
// cfg_    | APB write | psel & penable & pwrite    | tess_level at byte address 0
// A load is written to the control-point memory while the back end is idle; a cell is
// quicker when all four normals are degenerate, its time being set by the single Horner
// multiplier, the bit-serial square root, the shared divider and the normalize shifts.
// The two-entry input queue keeps accepting until full while the back end works or waits on out_ready.
// Reset is synchronous, active low; control points are undefined until loaded.
module bicubic_bezier_patch_tessellator_unit import bbpt_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_command,
  input  logic [3:0]         in_point_index,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  input  logic signed [31:0] in_coord_z,
  input  logic [7:0]         in_cell_u,
  input  logic [7:0]         in_cell_v,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [15:0] out_norm_x,
  output logic signed [15:0] out_norm_y,
  output logic signed [15:0] out_norm_z,
  output logic [16:0]        out_tex_s,
  output logic [16:0]        out_tex_t,
  output logic               out_last,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  logic [TESS_W-1:0] tess_r, tess_eff;
  logic              q_valid, q_pop, cfg_wr;
  req_t              q_req;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && !cfg_paddr[2];
  assign cfg_prdata = cfg_paddr[2] ? '0 : 32'(tess_r);
  assign tess_eff   = (tess_r == '0) ? TESS_W'(1) :
                      (tess_r > TESS_W'(MAX_TESS)) ? TESS_W'(MAX_TESS) : tess_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tess_r <= TESS_W'(1);
    end else if (cfg_wr) begin
      tess_r <= cfg_pwdata[TESS_W-1:0];
    end
  end

  bbpt_front #(.DEPTH(DEPTH)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_command    (in_command),
    .in_point_index(in_point_index),
    .in_coord_x    (in_coord_x),
    .in_coord_y    (in_coord_y),
    .in_coord_z    (in_coord_z),
    .in_cell_u     (in_cell_u),
    .in_cell_v     (in_cell_v),
    .tess_eff      (tess_eff),
    .q_valid       (q_valid),
    .q_req         (q_req),
    .q_pop         (q_pop)
  );

  bbpt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_req     (q_req),
    .q_pop     (q_pop),
    .tess_eff  (tess_eff),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_pos_x (out_pos_x),
    .out_pos_y (out_pos_y),
    .out_pos_z (out_pos_z),
    .out_norm_x(out_norm_x),
    .out_norm_y(out_norm_y),
    .out_norm_z(out_norm_z),
    .out_tex_s (out_tex_s),
    .out_tex_t (out_tex_t),
    .out_last  (out_last)
  );

`ifndef SYNTHESIS
  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> (tess_r == $past(cfg_pwdata[TESS_W-1:0])))
    else $error("tess_level write lost");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("request popped from empty queue");

  a_tess_range: assert property (@(posedge clk) disable iff (!rst_n)
    (tess_eff != '0) && (tess_eff <= TESS_W'(MAX_TESS)))
    else $error("effective tess level out of range");
`endif

endmodule

>>> tb/tb_bicubic_bezier_patch_checker.sv
module tb_bicubic_bezier_patch_checker import bbpt_pkg::*; #(
  parameter logic [2:0] TESS_ADDR = 3'd0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_command,
  input  logic [3:0]         in_point_index,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  input  logic signed [31:0] in_coord_z,
  input  logic [7:0]         in_cell_u,
  input  logic [7:0]         in_cell_v,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_pos_x,
  input  logic signed [31:0] out_pos_y,
  input  logic signed [31:0] out_pos_z,
  input  logic signed [15:0] out_norm_x,
  input  logic signed [15:0] out_norm_y,
  input  logic signed [15:0] out_norm_z,
  input  logic [16:0]        out_tex_s,
  input  logic [16:0]        out_tex_t,
  input  logic               out_last,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  input  logic               cfg_pready,
  output int                 pending,
  output int                 errors
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef longint vec3_t[3];
  typedef longint quad_t[4];

  typedef struct {
    logic signed [31:0] px, py, pz;
    logic signed [15:0] nx, ny, nz;
    logic [16:0]        s, t;
    logic               last;
  } vertex_t;

  vertex_t     vertex_q[$];
  longint      ctrl_pts[16][3];
  logic [8:0]  tess_reg;

  function automatic longint unsigned magn(longint x);
    return (x < 0) ? longint'(-x) : x;
  endfunction

  // round(a*u/2^16), halves up
  function automatic longint mul_rnd(longint a, longint u);
    longint hi;
    longint unsigned lo, fr;
    hi = a >>> FRAC_BITS;
    lo = a - (hi <<< FRAC_BITS);
    fr = (lo * longint'(u) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return hi * u + longint'(fr);
  endfunction

  // Bezier basis rows applied to p
  function automatic quad_t bez_coefs(quad_t p);
    quad_t k;
    k[0] = -p[0] + 3 * p[1] - 3 * p[2] + p[3];
    k[1] = 3 * p[0] - 6 * p[1] + 3 * p[2];
    k[2] = -3 * p[0] + 3 * p[1];
    k[3] = p[0];
    return k;
  endfunction

  function automatic longint bez_val(quad_t p, longint u);
    quad_t k;
    longint acc;
    k = bez_coefs(p);
    acc = mul_rnd(k[0], u) + k[1];
    acc = mul_rnd(acc, u) + k[2];
    return mul_rnd(acc, u) + k[3];
  endfunction

  function automatic longint bez_der(quad_t p, longint u);
    quad_t k;
    longint acc;
    k = bez_coefs(p);
    acc = mul_rnd(3 * k[0], u) + 2 * k[1];
    return mul_rnd(acc, u) + k[2];
  endfunction

  function automatic int shrink(vec3_t v, output vec3_t o);
    longint unsigned m;
    int s;
    m = magn(v[0]);
    if (magn(v[1]) > m) m = magn(v[1]);
    if (magn(v[2]) > m) m = magn(v[2]);
    s = 0;
    while ((m >> s) >= (64'd1 << 30)) s++;
    for (int a = 0; a < 3; a++) o[a] = v[a] >>> s;
    return s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic vec3_t surface_normal(vec3_t du, vec3_t dv);
    vec3_t a, b, c, n;
    longint unsigned m[3], big, sq, len, q;
    int s;
    bit tiny;
    s = shrink(du, a);
    s += shrink(dv, b);
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
    tiny = 1;
    for (int i = 0; i < 3; i++) begin
      m[i] = magn(c[i]);
      if (m[i] >= DEGEN_EPS) tiny = 0;
    end
    if (tiny) begin
      sq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
      if (sq == 0 || (s < 13 && (sq << (2 * s)) < 64'(DEGEN_EPS) * DEGEN_EPS)) begin
        n[0] = 0;
        n[1] = NORM_ONE;
        n[2] = 0;
        return n;
      end
    end
    big = m[0];
    if (m[1] > big) big = m[1];
    if (m[2] > big) big = m[2];
    while (big >= (64'd1 << 30)) begin
      big >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    while (big < (64'd1 << 29)) begin
      big <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
    for (int i = 0; i < 3; i++) begin
      q = (m[i] * NORM_ONE + len / 2) / len;
      n[i] = (c[i] < 0) ? -longint'(q) : longint'(q);
    end
    return n;
  endfunction

  task automatic eval_corner(longint u, longint v, output vec3_t pos, output vec3_t nrm);
    quad_t row, drow, pts;
    vec3_t du, dv;
    for (int a = 0; a < 3; a++) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) pts[c] = ctrl_pts[r * 4 + c][a];
        row[r]  = bez_val(pts, u);
        drow[r] = bez_der(pts, u);
      end
      pos[a] = bez_val(row, v);
      du[a]  = bez_val(drow, v);
      dv[a]  = bez_der(row, v);
      if (pos[a] > 64'sd2147483647) pos[a] = 64'sd2147483647;
      if (pos[a] < -64'sd2147483648) pos[a] = -64'sd2147483648;
    end
    nrm = surface_normal(du, dv);
  endtask

  task automatic tessellate_cell(longint ci, longint cj);
    int corner_order[6] = '{0, 1, 3, 0, 3, 2};
    longint lvl, pu[2], pv[2];
    vec3_t pos[4], nrm[4];
    vertex_t vx;
    int cn;
    lvl = tess_reg;
    if (lvl < 1) lvl = 1;
    if (lvl > MAX_TESS) lvl = MAX_TESS;
    if (ci >= lvl || cj >= lvl) return;
    for (int k = 0; k < 2; k++) begin
      pu[k] = ((ci + k) << FRAC_BITS) / lvl;
      pv[k] = ((cj + k) << FRAC_BITS) / lvl;
    end
    for (int k = 0; k < 4; k++) eval_corner(pu[k & 1], pv[k >> 1], pos[k], nrm[k]);
    for (int k = 0; k < 6; k++) begin
      cn = corner_order[k];
      vx.px = 32'(pos[cn][0]);
      vx.py = 32'(pos[cn][1]);
      vx.pz = 32'(pos[cn][2]);
      vx.nx = 16'(nrm[cn][0]);
      vx.ny = 16'(nrm[cn][1]);
      vx.nz = 16'(nrm[cn][2]);
      vx.s = 17'(pu[cn & 1]);
      vx.t = 17'(pv[cn >> 1]);
      vx.last = (k == 5);
      vertex_q.push_back(vx);
    end
  endtask

  task automatic report(string what, longint got, longint exp_v);
    $display("%0t: vertex %s mismatch: got %0d, expected %0d", $realtime, what, got, exp_v);
    errors++;
  endtask

  always @(posedge clk) begin
    vertex_t e;
    if (!rst_n) begin
      tess_reg <= 9'd1;
      errors = 0;
      vertex_q.delete();
      for (int i = 0; i < 16; i++) for (int a = 0; a < 3; a++) ctrl_pts[i][a] = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == TESS_ADDR)
        tess_reg <= cfg_pwdata[8:0];
      if (in_valid && in_ready) begin
        if (in_command == CMD_LOAD) begin
          ctrl_pts[in_point_index][0] = in_coord_x;
          ctrl_pts[in_point_index][1] = in_coord_y;
          ctrl_pts[in_point_index][2] = in_coord_z;
        end else begin
          tessellate_cell(in_cell_u, in_cell_v);
        end
      end
      if (out_valid && out_ready) begin
        if (vertex_q.size() == 0) begin
          $display("%0t: vertex with no request pending", $realtime);
          errors++;
        end else begin
          e = vertex_q.pop_front();
          if (out_pos_x !== e.px) report("pos_x", out_pos_x, e.px);
          if (out_pos_y !== e.py) report("pos_y", out_pos_y, e.py);
          if (out_pos_z !== e.pz) report("pos_z", out_pos_z, e.pz);
          if (out_norm_x !== e.nx) report("norm_x", out_norm_x, e.nx);
          if (out_norm_y !== e.ny) report("norm_y", out_norm_y, e.ny);
          if (out_norm_z !== e.nz) report("norm_z", out_norm_z, e.nz);
          if (out_tex_s !== e.s) report("tex_s", out_tex_s, e.s);
          if (out_tex_t !== e.t) report("tex_t", out_tex_t, e.t);
          if (out_last !== e.last) report("last", out_last, e.last);
        end
      end
    end
    pending = vertex_q.size();
  end

endmodule

>>> tb/tb_bicubic_bezier_patch_tessellator_unit.sv
module tb_bicubic_bezier_patch_tessellator_unit import bbpt_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] TESS_ADDR  = 3'd0;
  localparam logic [2:0] SPARE_ADDR = 3'd4;
  localparam int         DRAIN_CYC  = 2000;

  logic               clk, rst_n;
  logic               in_valid, in_ready, in_command;
  logic [3:0]         in_point_index;
  logic signed [31:0] in_coord_x, in_coord_y, in_coord_z;
  logic [7:0]         in_cell_u, in_cell_v;
  logic               out_valid, out_ready;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [15:0] out_norm_x, out_norm_y, out_norm_z;
  logic [16:0]        out_tex_s, out_tex_t;
  logic               out_last;
  logic               cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [2:0]         cfg_paddr;
  logic [31:0]        cfg_pwdata, cfg_prdata;
  int                 pending, errors;
  bit                 quiet;
  int                 cur_level;

  bicubic_bezier_patch_tessellator_unit dut (.*);

  tb_bicubic_bezier_patch_checker #(.TESS_ADDR(TESS_ADDR)) chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    out_ready = 0;
    @(posedge clk);
    forever begin
      if (quiet || $urandom_range(0, 2) != 0) begin
        out_ready <= 1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end else begin
        out_ready <= 0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
    end
  end

  task automatic send_request(logic cmd, logic [3:0] idx, logic [31:0] x, logic [31:0] y,
                              logic [31:0] z, logic [7:0] cu, logic [7:0] cv);
    bit ok;
    in_valid       <= 1;
    in_command     <= cmd;
    in_point_index <= idx;
    in_coord_x     <= x;
    in_coord_y     <= y;
    in_coord_z     <= z;
    in_cell_u      <= cu;
    in_cell_v      <= cv;
    do begin
      @(negedge clk);
      ok = in_ready;
      @(posedge clk);
    end while (!ok);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic load_point(logic [3:0] idx, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    send_request(CMD_LOAD, idx, x, y, z, 8'($urandom), 8'($urandom));
  endtask

  task automatic cell_request(logic [7:0] cu, logic [7:0] cv);
    send_request(CMD_CELL, 4'($urandom), $urandom, $urandom, $urandom, cu, cv);
  endtask

  task automatic drain;
    in_valid <= 0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
    cfg_psel    <= 1;
    cfg_penable <= 0;
    cfg_pwrite  <= 1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel    <= 0;
    cfg_penable <= 0;
    cfg_pwrite  <= 0;
    @(posedge clk);
    if (addr == TESS_ADDR) cur_level = data[8:0];
  endtask

  function automatic logic [31:0] rand_coord();
    if ($urandom_range(0, 1)) return $urandom;
    return $signed($urandom_range(0, 32'h7ffff)) - 32'sh40000;
  endfunction

  initial begin
    int levels[10] = '{0, 256, 5, 300, 2, 17, 511, 64, 1, 128};
    int eff, cu, cv;
    quiet = 0;
    cur_level = 1;
    rst_n = 0;
    in_valid = 0;
    in_command = CMD_LOAD;
    in_point_index = 0;
    in_coord_x = 0;
    in_coord_y = 0;
    in_coord_z = 0;
    in_cell_u = 0;
    in_cell_v = 0;
    cfg_psel = 0;
    cfg_penable = 0;
    cfg_pwrite = 0;
    cfg_paddr = 0;
    cfg_pwdata = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // flat patch: degenerate normal, then extreme coordinates on four points
    for (int i = 0; i < 16; i++) begin
      load_point(4'(i), 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    end
    cell_request(8'd0, 8'd0);
    cell_request(8'd0, 8'd1);
    cell_request(8'd255, 8'd255);
    load_point(4'd0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    load_point(4'd5, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000);
    load_point(4'd10, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    load_point(4'd15, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    cell_request(8'd0, 8'd0);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 9) quiet = 1;
      cfg_write(TESS_ADDR, levels[ph]);
      if (ph == 3) cfg_write(SPARE_ADDR, $urandom);
      eff = (cur_level < 1) ? 1 : (cur_level > MAX_TESS ? MAX_TESS : cur_level);
      for (int n = 0; n < 30; n++) begin
        if ($urandom_range(0, 9) < 3) begin
          load_point(4'($urandom), rand_coord(), rand_coord(), rand_coord());
        end else begin
          cu = $urandom_range(0, eff - 1);
          cv = $urandom_range(0, eff - 1);
          if (eff < 256 && $urandom_range(0, 6) == 0) begin
            if ($urandom_range(0, 1)) cu = $urandom_range(eff, 255);
            else cv = $urandom_range(eff, 255);
          end
          cell_request(8'(cu), 8'(cv));
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> bicubic_bezier_patch_tessellator_unit.f
sv/bbpt_pkg.sv
sv/bbpt_front.sv
sv/bbpt_div.sv
sv/bbpt_back.sv
sv/bicubic_bezier_patch_tessellator_unit.sv
tb/tb_bicubic_bezier_patch_checker.sv
tb/tb_bicubic_bezier_patch_tessellator_unit.sv
